>>> hw/rtl/ckblit_pkg.sv
// Package for the colour-keyed sprite blitter: widths, reset values, register indexes.
`timescale 1ns / 1ps

package ckblit_pkg;

    localparam int DIM_MAX_DEF  = 1024;

    localparam int DIM_W        = 11;   // size registers
    localparam int OFS_W        = 12;   // signed offsets
    localparam int PIX_W        = 16;
    localparam int IDX_W        = 20;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int OUT_DATA_W   = 40;   // dest_index + pixel_out, padded to bytes

    localparam logic [DIM_W-1:0] SPRITE_W_RST = 11'd1;
    localparam logic [DIM_W-1:0] SPRITE_H_RST = 11'd1;
    localparam logic [DIM_W-1:0] DEST_W_RST   = 11'd240;
    localparam logic [DIM_W-1:0] DEST_H_RST   = 11'd320;
    localparam logic [OFS_W-1:0] OFS_RST      = 12'd0;
    localparam logic [PIX_W-1:0] KEY_RST      = 16'hffff;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPRITE_W = 3'd0,
        REG_SPRITE_H = 3'd1,
        REG_DEST_W   = 3'd2,
        REG_DEST_H   = 3'd3,
        REG_X_OFS    = 3'd4,
        REG_Y_OFS    = 3'd5,
        REG_KEY      = 3'd6
    } cfg_reg_t;

endpackage

>>> hw/rtl/color_key_sprite_blit.sv
// Top level of the colour-keyed sprite blitter with destination clipping.
`timescale 1ns / 1ps

// Colour-keyed sprite blitter. Source sprite pixels arrive one per request on
// the s_axis side in raster order; each yields exactly one result on m_axis
// carrying the destination write enable (tuser), the linear destination index
// row * dest_width + column (tdata[19:0], zero when not written), the pixel
// itself (tdata[35:20]) and an end-of-sprite mark (tlast). A pixel is written
// only when it lands inside the destination after the signed offsets are
// applied and differs from the key colour. One pixel is accepted every clock
// cycle while m_axis takes results; each passes a position/clip stage, then the
// index multiply-add stage into the output register. Back-pressure from m_axis
// stalls both stages. Sprite sizes saturate to 1..DIM_MAX; the column and row
// counters wrap after the last sprite pixel. Configuration writes (cfg_valid,
// cfg_index, cfg_data) are always accepted and are meant to be made while no
// pixel is in flight; indexes beyond the register list are ignored.
module color_key_sprite_blit #(
    parameter int DIM_MAX = ckblit_pkg::DIM_MAX_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ckblit_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ckblit_pkg::CFG_DATA_W-1:0]  cfg_data,
    // source pixels
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ckblit_pkg::PIX_W-1:0]       s_axis_tdata,   // [15:0] pixel_in
    // results
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [ckblit_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // [19:0] dest_index,
                                                               // [35:20] pixel_out,
                                                               // [39:36] zero
    output logic                               m_axis_tuser,   // [0] write_enable
    output logic                               m_axis_tlast    // sprite_done
);

    localparam int CW  = $clog2(DIM_MAX);                       // counter width
    localparam int LW  = (CW + 1 > ckblit_pkg::DIM_W) ? CW + 1 : ckblit_pkg::DIM_W;
    localparam int DXW = ((CW > ckblit_pkg::OFS_W) ? CW : ckblit_pkg::OFS_W) + 1;
    localparam int DW  = ckblit_pkg::DIM_W;
    localparam int PW  = ckblit_pkg::PIX_W;
    localparam int IW  = ckblit_pkg::IDX_W;

    // ---------------- configuration registers ----------------
    logic [DW-1:0]                   sprite_w_reg, sprite_h_reg;
    logic [DW-1:0]                   dest_w_reg, dest_h_reg;
    logic [ckblit_pkg::OFS_W-1:0]    x_ofs_reg, y_ofs_reg;
    logic [PW-1:0]                   key_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sprite_w_reg <= ckblit_pkg::SPRITE_W_RST;
            sprite_h_reg <= ckblit_pkg::SPRITE_H_RST;
            dest_w_reg   <= ckblit_pkg::DEST_W_RST;
            dest_h_reg   <= ckblit_pkg::DEST_H_RST;
            x_ofs_reg    <= ckblit_pkg::OFS_RST;
            y_ofs_reg    <= ckblit_pkg::OFS_RST;
            key_reg      <= ckblit_pkg::KEY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (ckblit_pkg::cfg_reg_t'(cfg_index))
                ckblit_pkg::REG_SPRITE_W: sprite_w_reg <= cfg_data[DW-1:0];
                ckblit_pkg::REG_SPRITE_H: sprite_h_reg <= cfg_data[DW-1:0];
                ckblit_pkg::REG_DEST_W:   dest_w_reg   <= cfg_data[DW-1:0];
                ckblit_pkg::REG_DEST_H:   dest_h_reg   <= cfg_data[DW-1:0];
                ckblit_pkg::REG_X_OFS:    x_ofs_reg    <= cfg_data[ckblit_pkg::OFS_W-1:0];
                ckblit_pkg::REG_Y_OFS:    y_ofs_reg    <= cfg_data[ckblit_pkg::OFS_W-1:0];
                ckblit_pkg::REG_KEY:      key_reg      <= cfg_data[PW-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // ---------------- pipeline handshake ----------------
    logic s1_valid_reg, out_valid_reg;
    logic s1_adv, in_acc;

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- sprite position counters ----------------
    logic [CW-1:0] col_reg, row_reg;
    logic [CW-1:0] col_next, row_next;
    logic [LW-1:0] sw_eff, sh_eff;
    logic [LW-1:0] col_inc, row_inc;
    logic          last_col, last_row;

    // saturate a size register to 1..DIM_MAX
    function automatic logic [LW-1:0] clamp_dim(input logic [DW-1:0] v);
        logic [LW-1:0] vx;
        vx = LW'(v);
        if (v == '0)
            return LW'(1);
        else if (vx > LW'(DIM_MAX))
            return LW'(DIM_MAX);
        else
            return vx;
    endfunction

    function automatic logic [CW-1:0] col_inc_trunc(input logic [LW-1:0] v);
        return v[CW-1:0];
    endfunction

    always_comb
    begin
        sw_eff   = clamp_dim(sprite_w_reg);
        sh_eff   = clamp_dim(sprite_h_reg);
        col_inc  = LW'(col_reg) + LW'(1);
        row_inc  = LW'(row_reg) + LW'(1);
        // >= so that a size lowered mid-sprite still wraps
        last_col = col_inc >= sw_eff;
        last_row = row_inc >= sh_eff;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : col_inc_trunc(row_inc);
        end
        else
        begin
            col_next = col_inc_trunc(col_inc);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- stage 1: placement and clipping ----------------
    logic signed [DXW-1:0] dx, dy;
    logic                  on_dest;

    always_comb
    begin
        dx = signed'(DXW'(col_reg)) + DXW'(signed'(x_ofs_reg));
        dy = signed'(DXW'(row_reg)) + DXW'(signed'(y_ofs_reg));
        on_dest = !dx[DXW-1] && !dy[DXW-1]
               && (unsigned'(dx) < DXW'(dest_w_reg))
               && (unsigned'(dy) < DXW'(dest_h_reg));
    end

    logic [PW-1:0] s1_pix_reg;
    logic [DW-1:0] s1_dx_reg, s1_dy_reg;   // below the destination size when on_dest
    logic          s1_on_dest_reg, s1_done_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_pix_reg     <= s_axis_tdata;
            s1_dx_reg      <= dx[DW-1:0];
            s1_dy_reg      <= dy[DW-1:0];
            s1_on_dest_reg <= on_dest;
            s1_done_reg    <= last_col && last_row;
        end
    end

    // ---------------- stage 2: key test and linear index ----------------
    logic [2*DW-1:0] prod;
    logic [IW-1:0]   idx;
    logic            we;

    always_comb
    begin
        prod = s1_dy_reg * dest_w_reg;
        we   = s1_on_dest_reg && (s1_pix_reg != key_reg);
        idx  = we ? (prod[IW-1:0] + IW'(s1_dx_reg)) : '0;   // wraps modulo 2^20
    end

    logic [IW-1:0] out_idx_reg;
    logic [PW-1:0] out_pix_reg;
    logic          out_we_reg, out_done_reg;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_idx_reg  <= idx;
            out_pix_reg  <= s1_pix_reg;
            out_we_reg   <= we;
            out_done_reg <= s1_done_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(ckblit_pkg::OUT_DATA_W - IW - PW)'(0), out_pix_reg, out_idx_reg};
    assign m_axis_tuser  = out_we_reg;
    assign m_axis_tlast  = out_done_reg;

endmodule

>>> hw/rtl/ckblit_checker.sv
// Port-level checker for the sprite blitter, bound to the top level.
`timescale 1ns / 1ps

module ckblit_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [ckblit_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic                               m_axis_tuser,
    input logic                               m_axis_tlast
);

    // stalled result holds its payload
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result payload changed while stalled");

    a_out_hold_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result flags changed while stalled");

    // a pixel not written carries a zero index
    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[19:0] == 20'd0)
        else $error("non-zero index on a pixel not written");

    // input only stalls behind a pending result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

endmodule

bind color_key_sprite_blit ckblit_checker u_ckblit_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

>>> tb/color_key_sprite_blit_tb.sv
// Self-checking testbench for the colour-keyed sprite blitter.
`timescale 1ns / 1ps

// Pixels go in on s_axis with a random burst and gap pattern. Results on m_axis
// are taken with a stall pattern of their own and checked against a local
// predictor of the blit.
//
// The predictor keeps its own copy of the registers and of the column and row
// counters. For every pixel request that is accepted it works out the write
// enable, the linear destination index, the pixel and the end-of-sprite mark,
// and queues that result. The checker compares each result taken from m_axis
// with the oldest queued entry, one field at a time.
//
// Registers are only written while nothing is in flight. Every pixel gives
// exactly one result, so an empty queue means the pipeline is empty.
//
// Tests run in this order:
//   reset values  - 1x1 sprite, 240x320 destination, key 0xffff
//   edge cases    - sprite sizes that saturate, zero destination width,
//                   offsets at both extremes, index wrap past 20 bits,
//                   clipping on every side, key hits, unused register index
//   random blits  - small sprites with random placement, key and content,
//                   plus the odd noise setup with raw 16-bit register values
//   output stall  - sink holds off for a long stretch while the source keeps
//                   offering pixels, so the block fills and stalls its input
module color_key_sprite_blit_tb;

    import ckblit_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;  // beyond the list, ignored
    localparam int HOLD_CYCLES    = 150;
    localparam int QUIET_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] idx;
        logic [PIX_W-1:0] pix;
        logic             done;
    } blit_write_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata;     // [15:0] pixel_in
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;     // [19:0] dest_index, [35:20] pixel_out
    logic                  m_axis_tuser;     // [0] write_enable
    logic                  m_axis_tlast;     // sprite_done

    // register shadow, as the block holds them after masking
    logic [DIM_W-1:0]        sprite_w_q = SPRITE_W_RST;
    logic [DIM_W-1:0]        sprite_h_q = SPRITE_H_RST;
    logic [DIM_W-1:0]        dest_w_q   = DEST_W_RST;
    logic [DIM_W-1:0]        dest_h_q   = DEST_H_RST;
    logic signed [OFS_W-1:0] x_ofs_q    = OFS_RST;
    logic signed [OFS_W-1:0] y_ofs_q    = OFS_RST;
    logic [PIX_W-1:0]        key_q      = KEY_RST;

    // raster position of the next source pixel
    int col_pos = 0;
    int row_pos = 0;

    blit_write_t pending_writes[$];

    int mismatches   = 0;
    int pixels_sent  = 0;
    int burst_left   = 0;
    bit src_offering = 1'b0;    // mirrors s_axis_tvalid as last driven
    bit sender_gaps  = 1'b1;
    bit hold_off_req = 1'b0;
    int quiet_cycles = 0;

    color_key_sprite_blit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sizes saturate to 1..DIM_MAX
    function automatic int clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > DIM_MAX_DEF)
            return DIM_MAX_DEF;
        return int'(v);
    endfunction

    // Result for one source pixel at the current raster position; advances it.
    function automatic blit_write_t predict_write(input logic [PIX_W-1:0] pix);
        int          w;
        int          h;
        int          dx;
        int          dy;
        bit          last_col;
        bit          last_row;
        bit          on_dest;
        logic [31:0] lin;
        blit_write_t r;
        w = clamp_dim(sprite_w_q);
        h = clamp_dim(sprite_h_q);
        // position may sit past a size lowered since it advanced
        last_col = (col_pos + 1) >= w;
        last_row = (row_pos + 1) >= h;
        dx = col_pos + int'(x_ofs_q);
        dy = row_pos + int'(y_ofs_q);
        on_dest = dx >= 0 && dy >= 0 && dx < int'(dest_w_q) && dy < int'(dest_h_q);
        lin = 32'(dy) * 32'(dest_w_q) + 32'(dx);
        r.we   = on_dest && (pix != key_q);
        r.idx  = r.we ? lin[IDX_W-1:0] : '0;
        r.pix  = pix;
        r.done = last_col && last_row;
        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
        return r;
    endfunction

    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: mismatch: %s", $realtime, what);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
            note_mismatch($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
    endfunction

    // ---------------------------------------------------------------------
    // Result checker: every result taken is matched against the oldest entry.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        blit_write_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_writes.size() == 0)
                note_mismatch($sformatf("unexpected result tdata 0x%0h tuser %0b tlast %0b",
                                        m_axis_tdata, m_axis_tuser, m_axis_tlast));
            else
            begin
                want = pending_writes.pop_front();
                check_field("write_enable", 32'(want.we), 32'(m_axis_tuser));
                check_field("dest_index", 32'(want.idx), 32'(m_axis_tdata[IDX_W-1:0]));
                check_field("pixel_out", 32'(want.pix),
                            32'(m_axis_tdata[IDX_W+PIX_W-1:IDX_W]));
                check_field("sprite_done", 32'(want.done), 32'(m_axis_tlast));
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sink pacing: a rotating stall pattern, reloaded now and then, with
    // stretches of no stalling; a long hold-off when one is asked for.
    // ---------------------------------------------------------------------
    initial
    begin : sink_pacing
        int         hold_left;
        int         pat_left;
        logic [7:0] stall_pat;
        bit         free_run;
        hold_left = 0;
        pat_left  = 0;
        stall_pat = 8'hff;
        free_run  = 1'b1;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (pat_left == 0)
            begin
                pat_left  = $urandom_range(16, 96);
                free_run  = ($urandom_range(0, 3) == 0);
                stall_pat = 8'($urandom) | 8'h01;
            end
            pat_left--;
            stall_pat = {stall_pat[0], stall_pat[7:1]};
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= free_run | stall_pat[0];
        end
    end

    // ---------------------------------------------------------------------
    // Watchdog: too long without any request accepted on any channel.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $realtime, quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Leaves cfg_valid high so back-to-back writes need no drop in between.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= addr;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (addr)
            REG_SPRITE_W: sprite_w_q = val[DIM_W-1:0];
            REG_SPRITE_H: sprite_h_q = val[DIM_W-1:0];
            REG_DEST_W:   dest_w_q   = val[DIM_W-1:0];
            REG_DEST_H:   dest_h_q   = val[DIM_W-1:0];
            REG_X_OFS:    x_ofs_q    = val[OFS_W-1:0];
            REG_Y_OFS:    y_ofs_q    = val[OFS_W-1:0];
            REG_KEY:      key_q      = val[PIX_W-1:0];
            default: ;
        endcase
    endtask

    // Full register set, raw 16-bit values; a stray write to the unused
    // index sits in the middle and must change nothing.
    task automatic apply_setup(input logic [15:0] sw, input logic [15:0] sh,
                               input logic [15:0] dw, input logic [15:0] dh,
                               input logic [15:0] xo, input logic [15:0] yo,
                               input logic [15:0] key);
        write_reg(REG_SPRITE_W, sw);
        write_reg(REG_SPRITE_H, sh);
        write_reg(REG_DEST_W, dw);
        write_reg(REG_UNUSED, 16'($urandom));
        write_reg(REG_DEST_H, dh);
        write_reg(REG_X_OFS, xo);
        write_reg(REG_Y_OFS, yo);
        write_reg(REG_KEY, key);
        cfg_valid <= 1'b0;
    endtask

    // One pixel request. Valid stays high between back-to-back pixels; it is
    // dropped only for a gap between bursts.
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        if (sender_gaps && burst_left <= 0)
        begin
            if (src_offering)
                s_axis_tvalid <= 1'b0;
            src_offering = 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tdata  <= pix;
        s_axis_tvalid <= 1'b1;
        src_offering = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_writes.push_back(predict_write(pix));
        pixels_sent++;
    endtask

    // Stop offering and wait until every queued result has come out.
    task automatic wait_idle();
        if (src_offering)
            s_axis_tvalid <= 1'b0;
        src_offering = 1'b0;
        burst_left   = 0;
        while (pending_writes.size() != 0)
            @(posedge clk);
    endtask

    // 1x1 sprite at the origin of a 240x320 image: every pixel is a whole
    // sprite, written unless it is 0xffff.
    task automatic test_reset_values();
        send_pixel(16'hffff);
        send_pixel(16'h0000);
        send_pixel(16'h1234);
    endtask

    task automatic test_edge_cases();
        // width 0 saturates up to 1, height 2047 down to DIM_MAX; zero-width
        // destination clips everything
        wait_idle();
        apply_setup(16'h0000, 16'hffff, 16'h0000, 16'h0005, 16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'h0000);
        send_pixel(16'hffff);
        send_pixel(16'h5a5a);
        // biggest destination, row offset near its bottom: index wraps past
        // 20 bits; column -1 clips the left edge; key hit on the image
        wait_idle();
        apply_setup(16'h0003, 16'h0002, 16'h07ff, 16'h07ff, 16'h0fff, 16'h07f8, 16'h8000);
        send_pixel(16'h8000);
        send_pixel(16'h0001);
        send_pixel(16'h8000);
        send_pixel(16'hffff);
        send_pixel(16'h7fff);
        send_pixel(16'h0000);
        // most negative column, most positive row: nothing lands
        wait_idle();
        apply_setup(16'h0002, 16'h0002, 16'h0400, 16'h0400, 16'h0800, 16'h07ff, 16'h0000);
        repeat (4)
            send_pixel(16'($urandom));
        // 2x2 sprite shifted right and up on a 2x2 image: top and right clip;
        // upper bits of the size data are dropped
        wait_idle();
        apply_setup(16'h0002, 16'h0002, 16'hf802, 16'h0002, 16'h0001, 16'hffff, 16'h1234);
        send_pixel(16'h1234);
        send_pixel(16'hedcb);
        send_pixel(16'h0001);
        send_pixel(16'h1234);
    endtask

    task automatic test_random_blits(input int target);
        int          start;
        int          n;
        int          w;
        int          h;
        int          sel;
        logic [15:0] sw;
        logic [15:0] sh;
        logic [15:0] dw;
        logic [15:0] dh;
        logic [15:0] xo;
        logic [15:0] yo;
        logic [15:0] key;
        logic [15:0] pix;
        start = pixels_sent;
        while (pixels_sent - start < target)
        begin
            wait_idle();
            // mostly small sprites; now and then zero, large or raw noise
            case ($urandom_range(0, 9))
                0: sw = 16'h0000;
                1: sw = 16'($urandom);
                2: sw = 16'($urandom_range(9, 32));
                default: sw = 16'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 9))
                0: sh = 16'h0000;
                1: sh = 16'($urandom);
                default: sh = 16'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 9))
                0: dw = 16'h0000;
                1: dw = 16'($urandom);
                2: dw = 16'h07ff;
                default: dw = 16'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 9))
                0: dh = 16'h0000;
                1: dh = 16'($urandom);
                default: dh = 16'($urandom_range(1, 12));
            endcase
            // offsets straddle the destination edges so clipping hits all sides
            xo = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                             : 16'(int'($urandom_range(0, 20)) - 8);
            yo = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                             : 16'(int'($urandom_range(0, 20)) - 8);
            case ($urandom_range(0, 5))
                0: key = 16'hffff;
                1: key = 16'h0000;
                default: key = 16'($urandom);
            endcase
            apply_setup(sw, sh, dw, dh, xo, yo, key);
            w = clamp_dim(sw[DIM_W-1:0]);
            h = clamp_dim(sh[DIM_W-1:0]);
            n = (w * h <= 64) ? w * h * $urandom_range(1, 3) : $urandom_range(8, 40);
            repeat (n)
            begin
                sel = $urandom_range(0, 7);
                case (sel)
                    0, 1: pix = key;
                    2:    pix = 16'h0000;
                    3:    pix = 16'hffff;
                    default: pix = 16'($urandom);
                endcase
                send_pixel(pix);
            end
        end
    endtask

    // Sink holds off while the source streams without gaps: the block must
    // fill, drop s_axis_tready and lose nothing.
    task automatic test_output_stall();
        wait_idle();
        apply_setup(16'h0004, 16'h0003, 16'h0006, 16'h0005, 16'hfffe, 16'h0001,
                    16'h00ff);
        sender_gaps  = 1'b0;
        hold_off_req = 1'b1;
        repeat (100)
            send_pixel(($urandom_range(0, 3) == 0) ? 16'h00ff : 16'($urandom));
        sender_gaps = 1'b1;
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_edge_cases();
        test_random_blits(560);
        test_output_stall();
        test_random_blits(60);

        // everything out, then keep clocking to catch any stray result
        wait_idle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> color_key_sprite_blit.f
hw/rtl/ckblit_pkg.sv
hw/rtl/color_key_sprite_blit.sv
hw/rtl/ckblit_checker.sv
tb/color_key_sprite_blit_tb.sv
